>>> hw/rtl/bracket_balance_checker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bracket balance checker
// Each macro expects clk and rst_n in scope and reports through $error.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Condition holds at every edge outside reset
`define BBC_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bbc: invariant violated");

// Antecedent implies consequent in the same cycle
`define BBC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbc: implication violated");

// Antecedent implies consequent in the next cycle
`define BBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbc: next-cycle check violated");

`endif

>>> hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, character codes and status codes of the bracket checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int CHAR_W      = 8;
    localparam int OUT_LINE_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    // Token operations passed from the lexer to the stack engine
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    // Bracket kinds
    localparam logic [1:0] KIND_PAREN   = 2'd0;
    localparam logic [1:0] KIND_BRACE   = 2'd1;
    localparam logic [1:0] KIND_BRACKET = 2'd2;

    // Result status codes, also used as the latched error code
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OPEN      = 2'd1;
    localparam logic [1:0] ST_BAD_CLOSE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    // Control part of one token
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic       last;
    } tok_ctl_t;

    localparam int TOK_CTL_W = $bits(tok_ctl_t);

    function automatic logic [CHAR_W-1:0] opener_char(input logic [1:0] kind);
        logic [CHAR_W-1:0] ch;
        unique case (kind)
            KIND_PAREN:   ch = CH_LPAREN;
            KIND_BRACE:   ch = CH_LBRACE;
            KIND_BRACKET: ch = CH_LBRACK;
            default:      ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] closer_char(input logic [1:0] kind);
        logic [CHAR_W-1:0] ch;
        unique case (kind)
            KIND_PAREN:   ch = CH_RPAREN;
            KIND_BRACE:   ch = CH_RBRACE;
            KIND_BRACKET: ch = CH_RBRACK;
            default:      ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Lexer: accepts text bytes, tracks comment and string mode and the line
// count, and turns brackets and the final byte into tokens for the queue.
// ----------------------------------------------------------------------------
module bbc_front #(
    parameter int LINE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bbc_pkg::CHAR_W-1:0]   text_byte,
    input  logic                         final_byte,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic                         tok_valid,
    output bbc_pkg::tok_ctl_t            tok_ctl,
    output logic [LINE_WIDTH-1:0]        tok_line,
    input  logic                         q_full
);
    import bbc_pkg::*;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_ESCAPE  = 2'd3;

    localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

    logic [1:0]            mode_reg, mode_next;
    logic [LINE_WIDTH-1:0] line_reg, line_next;
    logic                  accept;
    logic [1:0]            op;
    logic [1:0]            kind;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the byte and advance lexer mode and line count
    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        op        = OP_NONE;
        kind      = KIND_PAREN;
        if (accept)
        begin
            if (text_byte == CH_NL && line_reg != LINE_MAX)
            begin
                line_next = line_reg + 1'b1;
            end
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (text_byte == CH_NL)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_STRING:
                begin
                    if (text_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_STRING;
                end
                default:
                begin
                    unique case (text_byte)
                        CH_SEMI:   mode_next = MODE_COMMENT;
                        CH_QUOTE:  mode_next = MODE_STRING;
                        CH_LPAREN: begin op = OP_PUSH; kind = KIND_PAREN;   end
                        CH_LBRACE: begin op = OP_PUSH; kind = KIND_BRACE;   end
                        CH_LBRACK: begin op = OP_PUSH; kind = KIND_BRACKET; end
                        CH_RPAREN: begin op = OP_POP;  kind = KIND_PAREN;   end
                        CH_RBRACE: begin op = OP_POP;  kind = KIND_BRACE;   end
                        CH_RBRACK: begin op = OP_POP;  kind = KIND_BRACKET; end
                        default:   ;
                    endcase
                end
            endcase
            // Start the next text from a clean state
            if (final_byte)
            begin
                mode_next = MODE_NORMAL;
                line_next = '0;
            end
        end
    end

    // Emit a token for brackets and for the end of the text
    assign tok_valid    = accept && (op != OP_NONE || final_byte);
    assign tok_ctl.op   = op;
    assign tok_ctl.kind = kind;
    assign tok_ctl.last = final_byte;
    assign tok_line     = line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            line_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
        end
    end

endmodule

>>> hw/rtl/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Short token queue between lexer and stack engine; lets each side stall
// on its own.
// ----------------------------------------------------------------------------
`include "bracket_balance_checker_assert.svh"

module bbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data,
    input  logic             rd_take
);
    import bbc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr_en, rd_en;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign wr_en    = wr_valid && !full;
    assign rd_en    = rd_take && rd_valid;

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `BBC_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(DEPTH))

endmodule

>>> hw/rtl/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: applies push and pop tokens to the bracket stack, latches
// the first error and delivers the result on the last token of a text.
// ----------------------------------------------------------------------------
`include "bracket_balance_checker_assert.svh"

module bbc_back #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_WIDTH  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tok_valid,
    input  bbc_pkg::tok_ctl_t              tok_ctl,
    input  logic [LINE_WIDTH-1:0]          tok_line,
    output logic                           tok_take,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [bbc_pkg::CHAR_W-1:0]     culprit_char,
    output logic [bbc_pkg::OUT_LINE_W-1:0] culprit_line
);
    import bbc_pkg::*;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = 2 + LINE_WIDTH;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_DEPTH);

    // Stack: top entry in flops, entries below it in memory; sub_reg holds
    // the entry just below the top, read ahead every cycle
    logic [ENTRY_W-1:0]    stack_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]    sub_reg;
    logic [1:0]            top_kind_reg, top_kind_next;
    logic [LINE_WIDTH-1:0] top_line_reg, top_line_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [1:0]            err_code_reg, err_code_next;
    logic [CHAR_W-1:0]     err_char_reg, err_char_next;
    logic [LINE_WIDTH-1:0] err_line_reg, err_line_next;

    logic                  mem_we;
    logic [LEVEL_W-1:0]    wr_full, rd_full;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;

    logic [1:0]            res_status;
    logic [CHAR_W-1:0]     res_char;
    logic [LINE_WIDTH-1:0] res_line;

    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [OUT_LINE_W-1:0] line_reg;

    // Take a token unless it carries a result that cannot be placed
    assign tok_take = tok_valid && (!tok_ctl.last || !out_valid_reg || !out_stall);

    // Apply the token to the stack and the error latch
    always_comb
    begin
        level_next    = level_reg;
        top_kind_next = top_kind_reg;
        top_line_next = top_line_reg;
        err_code_next = err_code_reg;
        err_char_next = err_char_reg;
        err_line_next = err_line_reg;
        mem_we        = 1'b0;
        res_status    = ST_OK;
        res_char      = CH_NUL;
        res_line      = '0;

        if (tok_take && err_code_reg == ST_OK)
        begin
            unique case (tok_ctl.op)
                OP_PUSH:
                begin
                    if (level_reg == LEVEL_FULL)
                    begin
                        err_code_next = ST_OVERFLOW;
                        err_char_next = opener_char(tok_ctl.kind);
                        err_line_next = tok_line;
                    end
                    else
                    begin
                        mem_we        = (level_reg != '0);
                        level_next    = level_reg + 1'b1;
                        top_kind_next = tok_ctl.kind;
                        top_line_next = tok_line;
                    end
                end
                OP_POP:
                begin
                    if (level_reg != '0 && top_kind_reg == tok_ctl.kind)
                    begin
                        level_next    = level_reg - 1'b1;
                        top_kind_next = sub_reg[ENTRY_W-1 -: 2];
                        top_line_next = sub_reg[LINE_WIDTH-1:0];
                    end
                    else
                    begin
                        err_code_next = ST_BAD_CLOSE;
                        err_char_next = closer_char(tok_ctl.kind);
                        err_line_next = tok_line;
                    end
                end
                default: ;
            endcase
        end

        // Form the report from the state after this token
        if (err_code_next != ST_OK)
        begin
            res_status = err_code_next;
            res_char   = err_char_next;
            res_line   = err_line_next;
        end
        else if (level_next != '0)
        begin
            res_status = ST_OPEN;
            res_char   = opener_char(top_kind_next);
            res_line   = top_line_next;
        end

        // Drop all text state after the report
        if (tok_take && tok_ctl.last)
        begin
            level_next    = '0;
            err_code_next = ST_OK;
            err_char_next = CH_NUL;
            err_line_next = '0;
        end
    end

    assign wr_full = level_reg - LEVEL_W'(1);
    assign wr_addr = wr_full[ADDR_W-1:0];
    assign rd_full = level_next - LEVEL_W'(2);
    assign rd_addr = rd_full[ADDR_W-1:0];

    // Spill the old top and read ahead the entry below the new top
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= {top_kind_reg, top_line_reg};
        end
        if (mem_we && wr_addr == rd_addr)
        begin
            sub_reg <= {top_kind_reg, top_line_reg};
        end
        else
        begin
            sub_reg <= stack_mem[rd_addr];
        end
        top_kind_reg <= top_kind_next;
        top_line_reg <= top_line_next;
    end

    // Hold control state and error latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            err_code_reg <= ST_OK;
            err_char_reg <= CH_NUL;
            err_line_reg <= '0;
        end
        else
        begin
            level_reg    <= level_next;
            err_code_reg <= err_code_next;
            err_char_reg <= err_char_next;
            err_line_reg <= err_line_next;
        end
    end

    // Output register: load on the last token, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tok_take && tok_ctl.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_take && tok_ctl.last)
        begin
            status_reg <= res_status;
            char_reg   <= res_char;
            line_reg   <= OUT_LINE_W'(res_line);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign culprit_char = char_reg;
    assign culprit_line = line_reg;

    `BBC_ASSERT_HOLDS(a_level_bound, level_reg <= LEVEL_FULL)
    `BBC_ASSERT_NEXT(a_error_sticky, err_code_reg != ST_OK && !(tok_take && tok_ctl.last), $stable(err_code_reg))
    `BBC_ASSERT_IMPLY(a_ok_clean, out_valid_reg && status_reg == ST_OK, char_reg == CH_NUL && line_reg == '0)

endmodule

>>> hw/rtl/bracket_balance_checker.sv
// A final byte's token passes through the token queue; its result is held in the stack engine's output register.
// Throughput: one byte per cycle while in_stall is low; neither the lexer nor the stack engine has a busy state.
// A two-entry token queue separates them, so output stalls hold only final-byte tokens.
// Reset (rst_n low, asynchronous) clears lexer mode, line count, stack level and error latch.
// Stack memory is not cleared; entries above the level are never used.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks nesting of (), {} and [] in a byte stream, skipping comments and
// strings, and reports the first fault or an unclosed bracket per text.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int LINE_WIDTH  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bbc_pkg::CHAR_W-1:0]     text_byte,
    input  logic                           final_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [bbc_pkg::CHAR_W-1:0]     culprit_char,
    output logic [bbc_pkg::OUT_LINE_W-1:0] culprit_line
);
    import bbc_pkg::*;

    localparam int Q_W = TOK_CTL_W + LINE_WIDTH;

    logic                  f_valid;
    tok_ctl_t              f_ctl;
    logic [LINE_WIDTH-1:0] f_line;
    logic                  q_full;
    logic                  q_valid;
    logic [Q_W-1:0]        q_rd_data;
    tok_ctl_t              q_ctl;
    logic [LINE_WIDTH-1:0] q_line;
    logic                  q_take;

    bbc_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tok_valid  (f_valid),
        .tok_ctl    (f_ctl),
        .tok_line   (f_line),
        .q_full     (q_full)
    );

    bbc_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_data  ({f_ctl, f_line}),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data),
        .rd_take  (q_take)
    );

    assign q_ctl  = tok_ctl_t'(q_rd_data[Q_W-1 -: TOK_CTL_W]);
    assign q_line = q_rd_data[LINE_WIDTH-1:0];

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_WIDTH  (LINE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_valid),
        .tok_ctl      (q_ctl),
        .tok_line     (q_line),
        .tok_take     (q_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .culprit_char (culprit_char),
        .culprit_line (culprit_line)
    );

endmodule
